FILE: rtl/divider_timer_with_frame_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Divider timer assertion macros
// Shared assertion forms used by the divider timer RTL.
// ----------------------------------------------------------------------------
`ifndef DIVIDER_TIMER_WITH_FRAME_SEQUENCER_DEFINES_SVH
`define DIVIDER_TIMER_WITH_FRAME_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DTFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define DTFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/dtfs_pkg.sv
// ----------------------------------------------------------------------------
// Divider timer package
// Payload structs, register indexes and constants of the divider timer block.
// ----------------------------------------------------------------------------
package dtfs_pkg;

	localparam int CC_W      = 16;
	localparam int TC_W      = 8;
	localparam int FD_W      = 8;
	localparam int RTC_W     = 27;
	localparam int PERIOD_W  = 26;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = PERIOD_W;
	localparam int TAP_IDX_W = 4;

	// Counter step per machine cycle and value after a divider write.
	localparam logic [CC_W-1:0]     CC_STEP = CC_W'(4);
	localparam logic [RTC_W-1:0]    RTC_STEP = RTC_W'(4);
	localparam logic [TAP_IDX_W-1:0] FRAME_TAP = TAP_IDX_W'(12);
	localparam logic [PERIOD_W-1:0] RTC_PERIOD_RESET = PERIOD_W'(4194304);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIMER_ENABLE = 3'd0,
		CFG_CLOCK_SELECT = 3'd1,
		CFG_RELOAD_VALUE = 3'd2,
		CFG_RTC_HALT     = 3'd3,
		CFG_RTC_PERIOD   = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CLK_SEL_BIT9 = 2'd0,
		CLK_SEL_BIT3 = 2'd1,
		CLK_SEL_BIT5 = 2'd2,
		CLK_SEL_BIT7 = 2'd3
	} clk_sel_t;

	typedef struct packed {
		logic advance;
		logic div_reset;
	} in_t;

	typedef struct packed {
		logic            timer_interrupt;
		logic [TC_W-1:0] timer_count;
		logic [7:0]      divider_value;
		logic            length_pulse;
		logic            sweep_pulse;
		logic            envelope_pulse;
		logic            second_pulse;
	} out_t;

	// Counter bit watched by the timer for a given clock select.
	function automatic logic [TAP_IDX_W-1:0] tap_index(input clk_sel_t sel);
		logic [TAP_IDX_W-1:0] idx;
		unique case (sel)
			CLK_SEL_BIT9: idx = TAP_IDX_W'(9);
			CLK_SEL_BIT3: idx = TAP_IDX_W'(3);
			CLK_SEL_BIT5: idx = TAP_IDX_W'(5);
			CLK_SEL_BIT7: idx = TAP_IDX_W'(7);
			default:      idx = TAP_IDX_W'(9);
		endcase
		return idx;
	endfunction

endpackage

FILE: rtl/divider_timer_with_frame_sequencer.sv
// ----------------------------------------------------------------------------
// Divider timer with frame sequencer
// Machine-cycle counter, programmable timer with delayed reload and
// interrupt, audio frame sequencer pulses and a seconds pulse generator.
// ----------------------------------------------------------------------------
// Each input transfer's result passes the input register, then the result
// register. Throughput: one item per cycle while out_ready is high; the
// whole tick update is one pass of logic between the input register and
// the result register.
// Reset: arst_n resets all counters, pipeline valids and configuration
// registers (rtc_period to 4194304); no clearing pass is needed.
module divider_timer_with_frame_sequencer
	import dtfs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_t                  out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "divider_timer_with_frame_sequencer_defines.svh"

	// Configuration registers
	logic                timer_enable_q;
	clk_sel_t            clock_select_q;
	logic [TC_W-1:0]     reload_value_q;
	logic                rtc_halt_q;
	logic [PERIOD_W-1:0] rtc_period_q;

	// Block state
	logic [CC_W-1:0]  cycle_counter_q;
	logic [TC_W-1:0]  timer_counter_q;
	logic             reload_pending_q;
	logic [FD_W-1:0]  frame_divider_q;
	logic [RTC_W-1:0] rtc_cycles_q;

	// Pipeline registers
	logic in_valid_s1;
	in_t  in_s1;
	logic out_valid_s2;
	out_t out_s2;

	logic step_s1;
	logic tick;

	// Next-state values for one tick
	logic [CC_W-1:0]      cc_next;
	logic                 frame_edge;
	logic [FD_W-1:0]      fd_next;
	logic [TAP_IDX_W-1:0] tap;
	logic                 timer_edge;
	logic [TC_W-1:0]      tc_base;
	logic [TC_W-1:0]      tc_next;
	logic                 pending_next;
	logic [RTC_W-1:0]     rtc_sum;
	logic                 rtc_hit;
	logic [RTC_W-1:0]     rtc_next;
	out_t                 result;

	// Stage 1 moves on when the result register is free or being drained.
	assign step_s1  = in_valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !in_valid_s1 || step_s1;
	assign tick     = step_s1 && in_s1.advance;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_enable_q <= 1'b0;
			clock_select_q <= CLK_SEL_BIT9;
			reload_value_q <= '0;
			rtc_halt_q     <= 1'b0;
			rtc_period_q   <= RTC_PERIOD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TIMER_ENABLE: timer_enable_q <= cfg_data[0];
				CFG_CLOCK_SELECT: clock_select_q <= clk_sel_t'(cfg_data[1:0]);
				CFG_RELOAD_VALUE: reload_value_q <= cfg_data[TC_W-1:0];
				CFG_RTC_HALT:     rtc_halt_q     <= cfg_data[0];
				CFG_RTC_PERIOD:   rtc_period_q   <= cfg_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// Cycle counter and frame sequencer
	always_comb begin
		cc_next    = in_s1.div_reset ? CC_STEP : cycle_counter_q + CC_STEP;
		frame_edge = cycle_counter_q[FRAME_TAP] && !cc_next[FRAME_TAP];
		fd_next    = frame_divider_q + FD_W'(1);
	end

	// Timer: a pending reload lands first, then an edge may increment.
	always_comb begin
		tap          = tap_index(clock_select_q);
		timer_edge   = timer_enable_q && cycle_counter_q[tap] && !cc_next[tap];
		tc_base      = reload_pending_q ? reload_value_q : timer_counter_q;
		tc_next      = tc_base + TC_W'(timer_edge);
		pending_next = timer_edge && (tc_next == '0);
	end

	// Seconds counter
	always_comb begin
		rtc_sum  = rtc_cycles_q + RTC_STEP;
		rtc_hit  = rtc_sum > RTC_W'(rtc_period_q);
		rtc_next = rtc_hit ? '0 : rtc_sum;
	end

	// Result of the current item
	always_comb begin
		if (in_s1.advance) begin
			result.timer_interrupt = reload_pending_q;
			result.timer_count     = tc_next;
			result.divider_value   = cc_next[CC_W-1 -: 8];
			result.length_pulse    = frame_edge && (fd_next[0] == 1'b0);
			result.sweep_pulse     = frame_edge && (fd_next[1:0] == 2'b00);
			result.envelope_pulse  = frame_edge && (fd_next[2:0] == 3'b000);
			result.second_pulse    = !rtc_halt_q && rtc_hit;
		end else begin
			result.timer_interrupt = 1'b0;
			result.timer_count     = timer_counter_q;
			result.divider_value   = cycle_counter_q[CC_W-1 -: 8];
			result.length_pulse    = 1'b0;
			result.sweep_pulse     = 1'b0;
			result.envelope_pulse  = 1'b0;
			result.second_pulse    = 1'b0;
		end
	end

	// State update on each tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_counter_q  <= '0;
			timer_counter_q  <= '0;
			reload_pending_q <= 1'b0;
			frame_divider_q  <= '0;
			rtc_cycles_q     <= '0;
		end else if (tick) begin
			cycle_counter_q  <= cc_next;
			timer_counter_q  <= tc_next;
			reload_pending_q <= pending_next;
			if (frame_edge) begin
				frame_divider_q <= fd_next;
			end
			if (!rtc_halt_q) begin
				rtc_cycles_q <= rtc_next;
			end
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (step_s1) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_s1) begin
			out_s2 <= result;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_data  = out_s2;

	// Checks
	`DTFS_ASSERT_NEXT(a_irq_follows_pending, clk, arst_n, tick && reload_pending_q, out_valid_s2 && out_s2.timer_interrupt, "pending reload did not raise the interrupt")
	`DTFS_ASSERT_NOW(a_pulse_nesting, clk, arst_n, out_valid_s2 && out_s2.envelope_pulse, out_s2.sweep_pulse && out_s2.length_pulse, "envelope pulse without sweep and length")
	`DTFS_ASSERT_NEXT(a_idle_item_quiet, clk, arst_n, step_s1 && !in_s1.advance, !out_s2.timer_interrupt && !out_s2.second_pulse && !out_s2.length_pulse, "item without advance raised an event")
	`DTFS_ASSERT_NEXT(a_stall_holds_s1, clk, arst_n, in_valid_s1 && !step_s1, in_valid_s1 && $stable(in_s1), "input register changed while stalled")

endmodule
